// ===== design/cvk2d_pkg.sv =====
// Shared types, constants and helpers for the 2-D constant-velocity Kalman filter.
package cvk2d_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned COV_W         = 48;
  localparam int unsigned REG_W         = 32;
  localparam int unsigned GAIN_W        = 33;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam logic [REG_W-1:0] PROC_NOISE_RST = 32'd1678;
  localparam logic [REG_W-1:0] MEAS_NOISE_RST = 32'd16777216;
  localparam logic [REG_W-1:0] INIT_ERR_RST   = 32'd16777216;

  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR   = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV0,
    ST_DIV1,
    ST_MX0H, ST_MX0L, ST_MX0A,
    ST_MY0H, ST_MY0L, ST_MY0A,
    ST_MX1H, ST_MX1L, ST_MX1A,
    ST_MY1H, ST_MY1L, ST_MY1A,
    ST_MA0H, ST_MA0L, ST_MA0A,
    ST_MB0H, ST_MB0L, ST_MB0A,
    ST_MB1H, ST_MB1L, ST_MB1A,
    ST_OUT
  } cvk2d_state_t;

  // divider control and status
  typedef struct packed {
    logic             start;
    logic [COV_W:0]   num;
    logic [COV_W:0]   den;
  } cvk2d_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [GAIN_W-1:0] quo;
  } cvk2d_div_rsp_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] lo;
    hi = (COORD_W+2)'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - (COORD_W+2)'(1);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COV_W-1:0] sat48(input logic [COV_W+2:0] v);
    if (v > (COV_W+3)'({COV_W{1'b1}})) begin
      return {COV_W{1'b1}};
    end
    return v[COV_W-1:0];
  endfunction

endpackage

// ===== design/cvk2d_if.sv =====
// Valid/ready stream interface for requests, results and register writes.
interface cvk2d_if #(
  parameter int unsigned W = 32
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/constant_velocity_kalman_2d.sv =====
// Top level of the 2-D constant-velocity Kalman filter.
//
//  channel | dir | payload
//  in      | in  | measure_x, measure_y, restart
//  out     | out | predicted_x, predicted_y
//  cfg     | in  | register index, write data
//
// After acceptance a request passes through predict, two gain divisions, seven
// hi/lo/add multiplier passes and the result state before it reaches out_valid.
// A division by zero (gain 0) or one whose gain saturates at one skips the bit steps.
// in_ready is low while the sequencer runs; the next request is taken only once it is
// back in idle. A stalled out side holds the sequencer only when a new result is
// ready while the previous one still waits in the output register.
// Synchronous active-low reset restores registers and the filter state.
module constant_velocity_kalman_2d #(
  parameter int unsigned COORD_FRAC_BITS = cvk2d_pkg::DEF_FRAC_BITS
) (
  input logic     clk,
  input logic     rst_n,
  cvk2d_if.sink   in_ch,
  cvk2d_if.source out_ch,
  cvk2d_if.sink   cfg_ch
);
  import cvk2d_pkg::*;

  logic [REG_W-1:0] pn_r, mn_r, ie_r;
  logic             core_busy, res_valid;
  logic signed [COORD_W-1:0] res_x, res_y;
  logic             ov_r;
  logic [2*COORD_W-1:0] od_r;
  logic             acc_in;
  logic             out_hold;

  // Q format does not change the arithmetic; checked only for its range
  localparam bit FRAC_OK = (COORD_FRAC_BITS >= 8) && (COORD_FRAC_BITS <= 24);

  assign cfg_ch.ready = FRAC_OK;
  assign in_ch.ready  = !core_busy;
  assign acc_in       = in_ch.valid && in_ch.ready;
  assign out_hold     = ov_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= PROC_NOISE_RST;
      mn_r <= MEAS_NOISE_RST;
      ie_r <= INIT_ERR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data[REG_W+CFG_IDX_W-1:REG_W])
        REG_PROC_NOISE: pn_r <= cfg_ch.data[REG_W-1:0];
        REG_MEAS_NOISE: mn_r <= cfg_ch.data[REG_W-1:0];
        REG_INIT_ERR:   ie_r <= cfg_ch.data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  cvk2d_core u_core (
    .clk(clk), .rst_n(rst_n), .start(acc_in), .hold(out_hold),
    .zx(in_ch.data[COORD_W-1:0]), .zy(in_ch.data[2*COORD_W-1:COORD_W]),
    .restart(in_ch.data[2*COORD_W]),
    .proc_noise(pn_r), .meas_noise(mn_r), .init_err(ie_r),
    .busy(core_busy), .res_valid(res_valid), .res_x(res_x), .res_y(res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_valid) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (res_valid) od_r <= {res_y, res_x};
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> !in_ch.ready) else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> ov_r) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r && $stable(od_r)) else $error("result dropped");
endmodule

// ===== design/cvk2d_div.sv =====
// Radix-2 restoring gain divider: floor(n*2^32/d), one quotient bit per cycle.
module cvk2d_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cvk2d_pkg::cvk2d_div_req_t req,
  output cvk2d_pkg::cvk2d_div_rsp_t rsp
);
  import cvk2d_pkg::*;

  localparam int unsigned STEPS = 32;

  logic [COV_W+1:0]    rem_r, rem_nxt;
  logic [COV_W:0]      den_r, den_nxt;
  logic [GAIN_W-1:0]   quo_r, quo_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [COV_W+1:0]    sh;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[COV_W:0], 1'b0};
    if (req.start) begin
      den_nxt = req.den;
      rem_nxt = {1'b0, req.num};
      cnt_nxt = '0;
      if (req.den == '0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else if (req.num >= req.den) begin
        quo_nxt  = GAIN_W'(64'h1_0000_0000);
        done_nxt = 1'b1;
      end else begin
        quo_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        quo_nxt = {quo_r[GAIN_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[GAIN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// ===== design/cvk2d_core.sv =====
// Sequencer, state registers and the shared 33x32 gain multiplier.
module cvk2d_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  hold,
  input  logic signed [cvk2d_pkg::COORD_W-1:0]  zx,
  input  logic signed [cvk2d_pkg::COORD_W-1:0]  zy,
  input  logic                                  restart,
  input  logic [cvk2d_pkg::REG_W-1:0]           proc_noise,
  input  logic [cvk2d_pkg::REG_W-1:0]           meas_noise,
  input  logic [cvk2d_pkg::REG_W-1:0]           init_err,
  output logic                                  busy,
  output logic                                  res_valid,
  output logic signed [cvk2d_pkg::COORD_W-1:0]  res_x,
  output logic signed [cvk2d_pkg::COORD_W-1:0]  res_y
);
  import cvk2d_pkg::*;

  cvk2d_state_t st_r, st_nxt;

  logic signed [COORD_W-1:0] px_r, py_r, vx_r, vy_r;
  logic signed [COORD_W-1:0] ppx_r, ppy_r;
  logic signed [COORD_W:0]   ex_r, ey_r;
  logic [COV_W-1:0]          ca_r, cb_r, cc_r;
  logic [COV_W-1:0]          a_r, b_r, c_r;
  logic [GAIN_W-1:0]         k0_r, k1_r;
  logic signed [COORD_W-1:0] zx_r, zy_r;
  logic                      rs_r;
  logic [COV_W+1:0]          s_r;
  logic [COV_W+1:0]          acc_r;
  logic [COV_W+16:0]         prod_r;

  cvk2d_div_req_t dreq;
  cvk2d_div_rsp_t drsp;

  cvk2d_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // predict, with restart applied first
  logic signed [COORD_W-1:0] ipx, ipy, ivx, ivy;
  logic [COV_W-1:0]          ica, icb, icc, qe, re;
  always_comb begin
    qe  = {8'd0, proc_noise, 8'd0};
    re  = {8'd0, meas_noise, 8'd0};
    ipx = rs_r ? '0 : px_r;
    ipy = rs_r ? '0 : py_r;
    ivx = rs_r ? '0 : vx_r;
    ivy = rs_r ? '0 : vy_r;
    ica = rs_r ? {8'd0, init_err, 8'd0} : ca_r;
    icb = rs_r ? '0 : cb_r;
    icc = rs_r ? {8'd0, init_err, 8'd0} : cc_r;
  end

  // shared multiplier: selects operand x (up to 50 bits split hi/lo) and gain
  logic [COV_W+1:0]  mx;
  logic [GAIN_W-1:0] mk;
  logic              mhi;
  logic [COV_W+16:0] mprod;
  always_comb begin
    mx  = '0;
    mk  = k0_r;
    mhi = 1'b0;
    unique case (st_r)
      ST_MX0H, ST_MX0L: begin mx = (COV_W+2)'(ex_r < 0 ? -ex_r : ex_r); mk = k0_r; end
      ST_MY0H, ST_MY0L: begin mx = (COV_W+2)'(ey_r < 0 ? -ey_r : ey_r); mk = k0_r; end
      ST_MX1H, ST_MX1L: begin mx = (COV_W+2)'(ex_r < 0 ? -ex_r : ex_r); mk = k1_r; end
      ST_MY1H, ST_MY1L: begin mx = (COV_W+2)'(ey_r < 0 ? -ey_r : ey_r); mk = k1_r; end
      ST_MA0H, ST_MA0L: begin mx = (COV_W+2)'(a_r); mk = k0_r; end
      ST_MB0H, ST_MB0L: begin mx = (COV_W+2)'(b_r); mk = k0_r; end
      ST_MB1H, ST_MB1L: begin mx = (COV_W+2)'(b_r); mk = k1_r; end
      default: begin mx = '0; mk = k0_r; end
    endcase
    unique case (st_r)
      ST_MX0H, ST_MY0H, ST_MX1H, ST_MY1H, ST_MA0H, ST_MB0H, ST_MB1H: mhi = 1'b1;
      default: mhi = 1'b0;
    endcase
    if (mhi) begin
      mprod = (COV_W+17)'({14'd0, mx[COV_W+1:32]} * mk);
    end else begin
      mprod = (COV_W+17)'(mx[31:0] * mk);
    end
  end

  // accumulated term = hi*k + (lo*k >> 32)
  logic [COV_W+1:0] term;
  assign term = acc_r + (COV_W+2)'(prod_r >> 32);

  logic signed [COORD_W+1:0] sterm_x, sterm_y;
  assign sterm_x = (ex_r < 0) ? -(COORD_W+2)'(signed'(term[COORD_W:0]))
                              :  (COORD_W+2)'(signed'(term[COORD_W:0]));
  assign sterm_y = (ey_r < 0) ? -(COORD_W+2)'(signed'(term[COORD_W:0]))
                              :  (COORD_W+2)'(signed'(term[COORD_W:0]));

  logic [COV_W+2:0] a_sum;
  assign a_sum = (COV_W+3)'(ica) + (COV_W+3)'({icb, 1'b0}) + (COV_W+3)'(icc) + (COV_W+3)'(qe);

  logic [COV_W-1:0] a_p;
  assign a_p = sat48(a_sum);

  always_comb begin
    st_nxt = st_r;
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = s_r[COV_W:0];
    unique case (st_r)
      ST_IDLE: if (start) st_nxt = ST_PRED;
      ST_PRED: st_nxt = ST_DIV0;
      ST_DIV0: begin
        if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = (COV_W+1)'(a_r);
        end
        if (drsp.done) st_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = (COV_W+1)'(b_r);
        end
        if (drsp.done) st_nxt = ST_MX0H;
      end
      ST_MX0H: st_nxt = ST_MX0L;
      ST_MX0L: st_nxt = ST_MX0A;
      ST_MX0A: st_nxt = ST_MY0H;
      ST_MY0H: st_nxt = ST_MY0L;
      ST_MY0L: st_nxt = ST_MY0A;
      ST_MY0A: st_nxt = ST_MX1H;
      ST_MX1H: st_nxt = ST_MX1L;
      ST_MX1L: st_nxt = ST_MX1A;
      ST_MX1A: st_nxt = ST_MY1H;
      ST_MY1H: st_nxt = ST_MY1L;
      ST_MY1L: st_nxt = ST_MY1A;
      ST_MY1A: st_nxt = ST_MA0H;
      ST_MA0H: st_nxt = ST_MA0L;
      ST_MA0L: st_nxt = ST_MA0A;
      ST_MA0A: st_nxt = ST_MB0H;
      ST_MB0H: st_nxt = ST_MB0L;
      ST_MB0L: st_nxt = ST_MB0A;
      ST_MB0A: st_nxt = ST_MB1H;
      ST_MB1H: st_nxt = ST_MB1L;
      ST_MB1L: st_nxt = ST_MB1A;
      ST_MB1A: st_nxt = ST_OUT;
      ST_OUT:  if (!hold) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      px_r <= '0;
      py_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
      ca_r <= {8'd0, INIT_ERR_RST, 8'd0};
      cb_r <= '0;
      cc_r <= {8'd0, INIT_ERR_RST, 8'd0};
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_PRED: begin
          px_r <= ipx;
          py_r <= ipy;
          vx_r <= ivx;
          vy_r <= ivy;
        end
        ST_MX0A: px_r <= sat32((COORD_W+2)'(ppx_r) + sterm_x);
        ST_MY0A: py_r <= sat32((COORD_W+2)'(ppy_r) + sterm_y);
        ST_MX1A: vx_r <= sat32((COORD_W+2)'(vx_r) + sterm_x);
        ST_MY1A: vy_r <= sat32((COORD_W+2)'(vy_r) + sterm_y);
        ST_MA0A: ca_r <= (COV_W+2)'(a_r) > term ? a_r - term[COV_W-1:0] : '0;
        ST_MB0A: cb_r <= (COV_W+2)'(b_r) > term ? b_r - term[COV_W-1:0] : '0;
        ST_MB1A: cc_r <= (COV_W+2)'(c_r) > term ? c_r - term[COV_W-1:0] : '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      zx_r <= zx;
      zy_r <= zy;
      rs_r <= restart;
    end
    if (st_r == ST_PRED) begin
      ppx_r <= sat32((COORD_W+2)'(ipx) + (COORD_W+2)'(ivx));
      ppy_r <= sat32((COORD_W+2)'(ipy) + (COORD_W+2)'(ivy));
      a_r   <= a_p;
      b_r   <= sat48((COV_W+3)'(icb) + (COV_W+3)'(icc));
      c_r   <= sat48((COV_W+3)'(icc) + (COV_W+3)'(qe));
      s_r   <= (COV_W+2)'(a_p) + (COV_W+2)'(re);
    end
    if (st_r == ST_DIV0) begin
      ex_r <= (COORD_W+1)'(zx_r) - (COORD_W+1)'(ppx_r);
      ey_r <= (COORD_W+1)'(zy_r) - (COORD_W+1)'(ppy_r);
    end
    if (st_r == ST_DIV0 && drsp.done) k0_r <= drsp.quo;
    if (st_r == ST_DIV1 && drsp.done) k1_r <= drsp.quo;
    prod_r <= mprod;
    if (mhi) begin
      acc_r <= '0;
    end else begin
      acc_r <= prod_r[COV_W+1:0];
    end
  end

  assign busy      = (st_r != ST_IDLE);
  assign res_valid = (st_r == ST_OUT) && !hold;
  assign res_x     = ppx_r;
  assign res_y     = ppy_r;
endmodule
